[hw/rtl/rgbc_pkg.sv]
// Shared types, constants and helpers for the RGB 3x3 convolution block.
package rgbc_pkg;

  localparam int CHAN_W   = 8;
  localparam int PROD_W   = 17;  // 9-bit signed pixel times 8-bit signed tap
  localparam int PART_W   = 19;  // sum of three products in one column
  localparam int SUM_W    = 21;  // sum of three column partials
  localparam int WRAP_W   = 16;  // accumulator wraps here
  localparam int CFG_W    = 64;
  localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_t;

  // one window column: rows top to bottom
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  // kernel taps for one window column
  typedef struct packed {
    logic [CHAN_W-1:0] top;
    logic [CHAN_W-1:0] mid;
    logic [CHAN_W-1:0] bot;
  } tap_col_t;

  // one line store entry: both stored rows at a column
  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } line_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,
    CELL_LOAD
  } cell_mode_t;

  typedef struct packed {
    logic       en;
    cell_mode_t mode;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_KERNEL_LOW   = 2'd2,
    REG_KERNEL_LAST  = 2'd3
  } cfg_idx_t;

  // wrap to 16 bits, then clamp to 0..255
  function automatic logic [CHAN_W-1:0] clamp_chan(input logic [SUM_W-1:0] s);
    logic [CHAN_W-1:0] r;
    if (s[WRAP_W-1]) begin
      r = '0;
    end else if (|s[WRAP_W-2:CHAN_W]) begin
      r = CHAN_MAX;
    end else begin
      r = s[CHAN_W-1:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/rgbc_if.sv]
// Pixel input and result output channel interfaces.
interface rgbc_pix_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;

  modport source (output valid, op, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, op, in_red, in_green, in_blue, output ready);
endinterface

interface rgbc_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       run_end;
  logic       frame_end;

  modport source (output valid, out_red, out_green, out_blue, run_end, frame_end,
                  input ready);
  modport sink   (input valid, out_red, out_green, out_blue, run_end, frame_end,
                  output ready);
endinterface

[hw/rtl/rgbc_line_ram.sv]
// Line store RAM: one write port, one registered read port.
module rgbc_line_ram #(
  parameter int DEPTH = 2048,
  parameter int DW    = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DW-1:0]            wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DW-1:0]            rdata
);

  logic [DW-1:0] mem [DEPTH];

  // write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while idle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/rgbc_cell.sv]
// Window column cell: holds one column of three pixels and its tap partials.
module rgbc_cell (
  input  logic                       clk,
  input  rgbc_pkg::cell_ctrl_t       ctrl,
  input  rgbc_pkg::col_t             shift_in,
  input  rgbc_pkg::col_t             load_in,
  input  rgbc_pkg::tap_col_t         taps,
  output rgbc_pkg::col_t             col,
  output logic signed [18:0]         part_red,
  output logic signed [18:0]         part_green,
  output logic signed [18:0]         part_blue
);
  import rgbc_pkg::*;

  // three-tap column sum for one channel
  function automatic logic signed [PART_W-1:0] col_sum(
    input logic [CHAN_W-1:0] a, input logic [CHAN_W-1:0] b,
    input logic [CHAN_W-1:0] c, input tap_col_t k);
    logic signed [PROD_W-1:0] pa;
    logic signed [PROD_W-1:0] pb;
    logic signed [PROD_W-1:0] pc;
    pa = $signed({1'b0, a}) * $signed(k.top);
    pb = $signed({1'b0, b}) * $signed(k.mid);
    pc = $signed({1'b0, c}) * $signed(k.bot);
    return {{(PART_W-PROD_W){pa[PROD_W-1]}}, pa}
         + {{(PART_W-PROD_W){pb[PROD_W-1]}}, pb}
         + {{(PART_W-PROD_W){pc[PROD_W-1]}}, pc};
  endfunction

  // column register
  always_ff @(posedge clk) begin
    unique case (ctrl.mode)
      CELL_SHIFT: col <= shift_in;
      CELL_LOAD:  col <= load_in;
      default:    col <= col;
    endcase
  end

  // partial sums from the held column
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      part_red   <= col_sum(col.top.red,   col.mid.red,   col.bot.red,   taps);
      part_green <= col_sum(col.top.green, col.mid.green, col.bot.green, taps);
      part_blue  <= col_sum(col.top.blue,  col.mid.blue,  col.bot.blue,  taps);
    end
  end

endmodule

[hw/rtl/rgb_conv3x3_edge_replicate.sv]
// Top level: RGB 3x3 convolution with replicated borders over a pixel stream.
//
//  channel | dir | handshake     | payload
//  pix_in  | in  | valid/ready   | op, in_red, in_green, in_blue
//  pix_out | out | valid/ready   | out_red, out_green, out_blue, run_end, frame_end
//  cfg     | in  | cfg_write     | cfg_index, cfg_data
//
// One item per cycle while the output is not stalled; a pixel that ends a row
// (past the first row) holds off the next item while the window shifts once
// more to give its second result. From accept to result: line store read at
// the accept edge, then window update, column partials, final sum and clamp;
// the second result of a row end follows the first. Reset (rst, synchronous)
// clears counters, pipeline valids and configuration registers; line stores
// are not cleared. A stalled result freezes the whole pipeline.
module rgb_conv3x3_edge_replicate #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic               clk,
  input  logic               rst,
  rgbc_pix_in_if.sink        pix_in,
  rgbc_pix_out_if.source     pix_out,
  input  logic               cfg_write,
  input  rgbc_pkg::cfg_idx_t cfg_index,
  input  logic [63:0]        cfg_data
);
  import rgbc_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = AW + 1;
  localparam int XW = (WW > 12) ? WW : 12;

  // configuration registers
  logic [11:0]      image_width;
  logic [15:0]      image_height;
  logic [CFG_W-1:0] kernel_first_eight;
  logic [7:0]       kernel_last_tap;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width        <= 12'd1;
      image_height       <= 16'd1;
      kernel_first_eight <= 64'h0000_0001_0000_0000;
      kernel_last_tap    <= 8'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width        <= cfg_data[11:0];
        REG_IMAGE_HEIGHT: image_height       <= cfg_data[15:0];
        REG_KERNEL_LOW:   kernel_first_eight <= cfg_data;
        REG_KERNEL_LAST:  kernel_last_tap    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  function automatic logic [AW-1:0] clamp_col(input logic [WW-1:0] c,
                                              input logic [WW-1:0] w);
    logic [WW-1:0] t;
    t = (c >= w) ? (w - WW'(1)) : c;
    return t[AW-1:0];
  endfunction

  // counters and pipeline control
  logic [AW-1:0] col_cnt;
  logic [15:0]   row_cnt;
  logic [AW-1:0] drain_cnt;
  logic          en, rdy, extra;
  logic          accept, pix_do, drain_do;

  // effective frame size
  logic [XW-1:0] iw_x;
  logic [WW-1:0] w_eff;
  logic [15:0]   h_eff;
  always_comb begin
    iw_x = XW'(image_width);
    if (image_width == 12'd0) begin
      w_eff = WW'(1);
    end else if (iw_x > XW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = iw_x[WW-1:0];
    end
    h_eff = (image_height == 16'd0) ? 16'd1 : image_height;
  end

  // accept-side decode
  logic [WW-1:0] col_x, d_x, dm1_x, dp1_x;
  logic          row_done, first_row, frame_busy, fend;
  logic [AW-1:0] ci, cl, cm, cr;
  pix_t          cur;
  always_comb begin
    col_x      = {1'b0, col_cnt};
    d_x        = {1'b0, drain_cnt};
    dm1_x      = (drain_cnt == '0) ? '0 : (d_x - WW'(1));
    dp1_x      = d_x + WW'(1);
    row_done   = (col_x + WW'(1)) >= w_eff;
    first_row  = (row_cnt == 16'd0);
    frame_busy = (row_cnt >= h_eff);
    fend       = (dp1_x >= w_eff);
    ci         = clamp_col(col_x, w_eff);
    cl         = clamp_col(dm1_x, w_eff);
    cm         = clamp_col(d_x, w_eff);
    cr         = clamp_col(dp1_x, w_eff);
    cur        = '{red: pix_in.in_red, green: pix_in.in_green, blue: pix_in.in_blue};
  end

  assign en       = !pix_out.valid || pix_out.ready;
  assign rdy      = en && !extra;
  assign pix_in.ready = rdy;
  assign accept   = pix_in.valid && rdy;
  assign pix_do   = accept && !pix_in.op && !frame_busy;
  assign drain_do = accept && pix_in.op && frame_busy;

  // frame counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt   <= '0;
      row_cnt   <= '0;
      drain_cnt <= '0;
    end else if (pix_do) begin
      if (row_done) begin
        col_cnt <= '0;
        row_cnt <= row_cnt + 16'd1;
      end else begin
        col_cnt <= col_cnt + AW'(1);
      end
    end else if (drain_do) begin
      if (fend) begin
        col_cnt   <= '0;
        row_cnt   <= '0;
        drain_cnt <= '0;
      end else begin
        drain_cnt <= drain_cnt + AW'(1);
      end
    end
  end

  // stage 1 item
  logic          s1_valid, s1_drain, s1_first, s1_col0, s1_row_done, s1_fend;
  logic [AW-1:0] s1_a0, s1_a1, s1_a2;
  pix_t          s1_cur;
  logic          proc;

  assign proc = en && s1_valid && !extra;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      extra    <= 1'b0;
    end else if (en) begin
      extra <= proc && !s1_drain && s1_row_done && !s1_first;
      if (!extra) begin
        s1_valid <= pix_do || drain_do;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_drain    <= pix_in.op;
      s1_first    <= first_row;
      s1_col0     <= (col_cnt == '0);
      s1_row_done <= row_done;
      s1_fend     <= fend;
      s1_cur      <= cur;
      s1_a0       <= pix_in.op ? cl : ci;
      s1_a1       <= cm;
      s1_a2       <= cr;
    end
  end

  // line stores: three copies for three read addresses
  line_t         rd0, rd1, rd2, f0, f1, f2, wdata;
  logic          wr_en, lw_valid;
  logic [AW-1:0] lw_addr;
  line_t         lw_data;

  rgbc_line_ram #(.DEPTH(MAX_WIDTH), .DW($bits(line_t))) u_ram0 (
    .clk(clk), .we(wr_en), .waddr(s1_a0), .wdata(wdata),
    .re(accept), .raddr(pix_in.op ? cl : ci), .rdata(rd0));
  rgbc_line_ram #(.DEPTH(MAX_WIDTH), .DW($bits(line_t))) u_ram1 (
    .clk(clk), .we(wr_en), .waddr(s1_a0), .wdata(wdata),
    .re(accept), .raddr(cm), .rdata(rd1));
  rgbc_line_ram #(.DEPTH(MAX_WIDTH), .DW($bits(line_t))) u_ram2 (
    .clk(clk), .we(wr_en), .waddr(s1_a0), .wdata(wdata),
    .re(accept), .raddr(cr), .rdata(rd2));

  // write landing on the same edge as a read is forwarded
  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (accept) begin
      lw_valid <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lw_addr <= s1_a0;
      lw_data <= wdata;
    end
  end

  assign f0 = (lw_valid && lw_addr == s1_a0) ? lw_data : rd0;
  assign f1 = (lw_valid && lw_addr == s1_a1) ? lw_data : rd1;
  assign f2 = (lw_valid && lw_addr == s1_a2) ? lw_data : rd2;

  // new column and store update for a pixel
  col_t newcol;
  always_comb begin
    newcol.top = s1_first ? s1_cur : f0.upper;
    newcol.mid = s1_first ? s1_cur : f0.middle;
    newcol.bot = s1_cur;
    wdata.upper  = newcol.mid;
    wdata.middle = s1_cur;
    wr_en = proc && !s1_drain;
  end

  // window cells
  col_t       cols [3];
  col_t       shift_src [3];
  col_t       load_src [3];
  cell_ctrl_t cctl;
  tap_col_t   tcol [3];
  logic [7:0] taps [9];
  logic signed [PART_W-1:0] pr [3];
  logic signed [PART_W-1:0] pg [3];
  logic signed [PART_W-1:0] pb [3];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      taps[i] = kernel_first_eight[8*i +: 8];
    end
    taps[8] = kernel_last_tap;
  end

  always_comb begin
    cctl.en   = en;
    cctl.mode = CELL_HOLD;
    if (en && extra) begin
      cctl.mode = CELL_SHIFT;
    end else if (proc) begin
      cctl.mode = (s1_drain || s1_col0) ? CELL_LOAD : CELL_SHIFT;
    end
    shift_src[0] = cols[1];
    shift_src[1] = cols[2];
    shift_src[2] = extra ? cols[2] : newcol;
    load_src[0]  = s1_drain ? col_t'{f0.upper, f0.middle, f0.middle} : newcol;
    load_src[1]  = s1_drain ? col_t'{f1.upper, f1.middle, f1.middle} : newcol;
    load_src[2]  = s1_drain ? col_t'{f2.upper, f2.middle, f2.middle} : newcol;
  end

  for (genvar j = 0; j < 3; j++) begin : g_cell
    assign tcol[j] = '{top: taps[j], mid: taps[3+j], bot: taps[6+j]};
    rgbc_cell u_cell (
      .clk(clk), .ctrl(cctl), .shift_in(shift_src[j]), .load_in(load_src[j]),
      .taps(tcol[j]), .col(cols[j]),
      .part_red(pr[j]), .part_green(pg[j]), .part_blue(pb[j]));
  end

  // result flags alongside the window and partials
  logic emit_now, emit_run, emit_fend;
  logic e1_valid, e1_run, e1_fend, e2_valid, e2_run, e2_fend;

  always_comb begin
    emit_now  = 1'b0;
    emit_run  = 1'b1;
    emit_fend = 1'b0;
    if (en && extra) begin
      emit_now = 1'b1;
    end else if (proc && s1_drain) begin
      emit_now  = 1'b1;
      emit_fend = s1_fend;
    end else if (proc) begin
      emit_now = !s1_first && !s1_col0;
      emit_run = !s1_row_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_valid      <= 1'b0;
      e2_valid      <= 1'b0;
      pix_out.valid <= 1'b0;
    end else if (en) begin
      e1_valid      <= emit_now;
      e2_valid      <= e1_valid;
      pix_out.valid <= e2_valid;
    end
  end

  // final sum, wrap and clamp
  function automatic logic [SUM_W-1:0] sum3(input logic signed [PART_W-1:0] a,
                                            input logic signed [PART_W-1:0] b,
                                            input logic signed [PART_W-1:0] c);
    return {{(SUM_W-PART_W){a[PART_W-1]}}, a}
         + {{(SUM_W-PART_W){b[PART_W-1]}}, b}
         + {{(SUM_W-PART_W){c[PART_W-1]}}, c};
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      e1_run            <= emit_run;
      e1_fend           <= emit_fend;
      e2_run            <= e1_run;
      e2_fend           <= e1_fend;
      pix_out.run_end   <= e2_run;
      pix_out.frame_end <= e2_fend;
      pix_out.out_red   <= clamp_chan(sum3(pr[0], pr[1], pr[2]));
      pix_out.out_green <= clamp_chan(sum3(pg[0], pg[1], pg[2]));
      pix_out.out_blue  <= clamp_chan(sum3(pb[0], pb[1], pb[2]));
    end
  end

  // checks
  a_fend_run: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid && pix_out.frame_end |-> pix_out.run_end)
    else $error("frame end without run end");

  a_row_end_hold: assert property (@(posedge clk) disable iff (rst)
    proc && !s1_drain && s1_row_done && !s1_first |=> !pix_in.ready)
    else $error("input taken during second result of a row end");

  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    drain_do && fend |=> row_cnt == 16'd0 && col_cnt == '0 && drain_cnt == '0)
    else $error("counters not cleared at frame end");

endmodule
